// ----- src/mcm_pkg.sv -----
// Shared constants and types for the maze cluster merge unit.
package mcm_pkg;
   localparam int MaxSideDefault = 63;
   localparam int LabelWidth = 12;
   localparam logic [1:0] CMD_INIT = 2'd0;
   localparam logic [1:0] CMD_TRY  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic CSR_GRID_SIZE = 1'b0;
   localparam logic CSR_LOOP_THRESHOLD = 1'b1;
   localparam logic [1:0] KIND_WALL  = 2'd0;
   localparam logic [1:0] KIND_FLOOR = 2'd1;
   localparam logic [1:0] KIND_GOAL  = 2'd2;
   localparam logic [LabelWidth-1:0] LBL_SOLID  = '0;
   localparam logic [LabelWidth-1:0] LBL_BRK_LR = '1;
   localparam logic [LabelWidth-1:0] LBL_BRK_UD = {{(LabelWidth-1){1'b1}}, 1'b0};
   localparam logic [LabelWidth-1:0] LBL_FIRST  = 12'd2;

   typedef struct packed {
      logic       opened;
      logic [1:0] cell_kind;
   } result_type;
endpackage

// ----- src/mcm_grid_mem.sv -----
// Label grid memory: one write port, one registered read port.
module mcm_grid_mem import mcm_pkg::*; #(
   parameter int Depth = MaxSideDefault * MaxSideDefault,
   parameter int AddrWidth = $clog2(Depth)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AddrWidth-1:0]  wr_addr,
   input  logic [LabelWidth-1:0] wr_data,
   input  logic [AddrWidth-1:0]  rd_addr,
   output logic [LabelWidth-1:0] rd_data
);
   logic [LabelWidth-1:0] mem [Depth];
   logic [LabelWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- src/mcm_queue_mem.sv -----
// Flood fill queue memory: one write port, one registered read port.
module mcm_queue_mem import mcm_pkg::*; #(
   parameter int Depth = MaxSideDefault * MaxSideDefault,
   parameter int AddrWidth = $clog2(Depth),
   parameter int DataWidth = 2 * $clog2(MaxSideDefault + 1)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [DataWidth-1:0] wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [DataWidth-1:0] rd_data
);
   logic [DataWidth-1:0] mem [Depth];
   logic [DataWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- src/maze_cluster_merge_unit.sv -----
// Maze builder: init sweep, wall try, flood fill relabel, and cell read.
// A read fetches one cell; init writes every cell of the side*side grid; a try checks the
// wall cell and, if breakable, the cells on both sides, then writes the wall and, when it
// opens, flood fills the region. Out-of-grid or pre-init items go straight to the response.
// One item at a time: a new request is taken only when the unit is idle.
// Reset clears the control state; the grid is undefined and reads as wall until init.
module maze_cluster_merge_unit import mcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[1:0], row[7:2], col[13:8], rand_value[23:14]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // opened[0], cell_kind[2:1]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [9:0]  csr_data
);
   localparam int MaxSide = MaxSideDefault;
   localparam int Depth = MaxSide * MaxSide;
   localparam int AddrWidth = $clog2(Depth);
   localparam int CoordWidth = $clog2(MaxSide + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT, ST_RD_WAIT, ST_RD_DONE, ST_TW_WAIT, ST_TW_CHECK,
      ST_TA_WAIT, ST_TA_GET, ST_TB_WAIT, ST_TB_GET, ST_FL_POP, ST_FL_QWAIT,
      ST_FL_NB, ST_FL_NWAIT, ST_FL_NCHK, ST_RESP
   } state_type;

   state_type state_ff;
   logic [5:0] grid_size_ff;
   logic [9:0] thresh_ff;
   logic [CoordWidth-1:0] side_ff;
   logic ready_ff;
   logic [CoordWidth-1:0] row_ff, col_ff, qr_ff, qc_ff;
   logic [9:0] rnd_ff;
   logic [LabelWidth-1:0] first_ff, next_lbl_ff, wall_ff;
   logic [AddrWidth-1:0] head_ff, tail_ff, wall_addr_ff, nb_addr_ff;
   logic [1:0] k_ff;
   result_type res_ff;
   result_type rsp_data_ff;
   logic rsp_valid_ff;

   logic g_we, q_we;
   logic [AddrWidth-1:0] g_waddr, g_raddr, q_waddr, q_raddr;
   logic [2*CoordWidth-1:0] q_wdata, q_rdata;
   logic [LabelWidth-1:0] g_wdata, g_rdata;

   mcm_grid_mem #(.Depth(Depth)) u_grid (
      .clock(clock), .wr_en(g_we), .wr_addr(g_waddr), .wr_data(g_wdata),
      .rd_addr(g_raddr), .rd_data(g_rdata));
   mcm_queue_mem #(.Depth(Depth), .DataWidth(2 * CoordWidth)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata));

   function automatic logic [AddrWidth-1:0] at(input logic [CoordWidth-1:0] r,
                                             input logic [CoordWidth-1:0] c);
      logic [2*AddrWidth-1:0] p;
      p = r * MaxSide[AddrWidth-1:0] + c;
      return p[AddrWidth-1:0];
   endfunction

   // Clamped, odd side taken at init.
   logic [CoordWidth-1:0] side_calc;
   always_comb begin
      logic [CoordWidth:0] n;
      n = (CoordWidth+1)'(grid_size_ff);
      if (n < (CoordWidth+1)'(5)) n = (CoordWidth+1)'(5);
      if (n > (CoordWidth+1)'(MaxSide)) n = (CoordWidth+1)'(MaxSide);
      if (!n[0]) n = n - 1'b1;
      side_calc = n[CoordWidth-1:0];
   end

   logic [CoordWidth-1:0] req_row, req_col;
   assign req_row = CoordWidth'(req_tdata[7:2]);
   assign req_col = CoordWidth'(req_tdata[13:8]);

   // Neighbor in direction k: right, up, left, down.
   logic nb_ok;
   logic [CoordWidth-1:0] nb_r, nb_c;
   always_comb begin
      nb_r = qr_ff;
      nb_c = qc_ff;
      nb_ok = 1'b1;
      case (k_ff)
         2'd0: begin nb_c = qc_ff + 1'b1; nb_ok = (qc_ff + 1'b1) < side_ff; end
         2'd1: begin nb_r = qr_ff - 1'b1; nb_ok = qr_ff != '0; end
         2'd2: begin nb_c = qc_ff - 1'b1; nb_ok = qc_ff != '0; end
         default: begin nb_r = qr_ff + 1'b1; nb_ok = (qr_ff + 1'b1) < side_ff; end
      endcase
   end

   logic g_pos;
   assign g_pos = !g_rdata[LabelWidth-1] && g_rdata != '0;

   // Init sweep value at (row_ff, col_ff).
   logic [LabelWidth-1:0] init_val;
   always_comb begin
      logic inner;
      inner = row_ff >= 1 && row_ff < side_ff - 1'b1 &&
              col_ff >= 1 && col_ff < side_ff - 1'b1;
      init_val = LBL_SOLID;
      if (inner) begin
         if (row_ff[0] && col_ff[0]) init_val = next_lbl_ff;
         else if (row_ff[0]) init_val = LBL_BRK_LR;
         else if (col_ff[0]) init_val = LBL_BRK_UD;
      end
   end

   // Each grid wait state repeats the read address of the state before it, so the
   // registered read data is still valid when the next state uses it.
   always_comb begin
      g_we = 1'b0;
      g_waddr = at(row_ff, col_ff);
      g_wdata = init_val;
      g_raddr = at(row_ff, col_ff);
      q_we = 1'b0;
      q_waddr = tail_ff;
      q_wdata = {row_ff, col_ff};
      q_raddr = head_ff;
      unique case (state_ff)
         ST_INIT: g_we = 1'b1;
         ST_IDLE: g_raddr = at(req_row, req_col);
         ST_TW_CHECK: begin
            if (g_rdata == LBL_BRK_LR) g_raddr = at(row_ff, col_ff + 1'b1);
            else g_raddr = at(row_ff + 1'b1, col_ff);
         end
         ST_TA_WAIT: begin
            if (wall_ff == LBL_BRK_LR) g_raddr = at(row_ff, col_ff + 1'b1);
            else g_raddr = at(row_ff + 1'b1, col_ff);
         end
         ST_TA_GET, ST_TB_WAIT: begin
            if (wall_ff == LBL_BRK_LR) g_raddr = at(row_ff, col_ff - 1'b1);
            else g_raddr = at(row_ff - 1'b1, col_ff);
         end
         ST_TB_GET: begin
            g_waddr = wall_addr_ff;
            g_we = 1'b1;
            q_we = 1'b1;
            q_waddr = '0;
            if (first_ff != g_rdata || rnd_ff < thresh_ff) g_wdata = first_ff;
            else begin g_wdata = LBL_SOLID; q_we = 1'b0; end
         end
         ST_FL_NB: g_raddr = at(nb_r, nb_c);
         ST_FL_NWAIT: g_raddr = nb_addr_ff;
         ST_FL_NCHK: begin
            g_waddr = nb_addr_ff;
            g_wdata = first_ff;
            q_wdata = {nb_r, nb_c};
            if (g_pos && g_rdata != first_ff) begin g_we = 1'b1; q_we = 1'b1; end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         grid_size_ff <= 6'd31;
         thresh_ff <= 10'd30;
         side_ff <= '0;
         ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GRID_SIZE) grid_size_ff <= csr_data[5:0];
            else thresh_ff <= csr_data;
         end
         // The output register frees the working result for the next item.
         if (state_ff == ST_RESP && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff <= res_ff;
         end else if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_tvalid) begin
               row_ff <= (req_tdata[1:0] == CMD_INIT) ? '0 : req_row;
               col_ff <= (req_tdata[1:0] == CMD_INIT) ? '0 : req_col;
               rnd_ff <= req_tdata[23:14];
               res_ff <= '0;
               wall_addr_ff <= at(req_row, req_col);
               if (req_tdata[1:0] == CMD_INIT) begin
                  side_ff <= side_calc;
                  next_lbl_ff <= LBL_FIRST;
                  state_ff <= ST_INIT;
               end else if (req_tdata[1:0] == CMD_TRY || req_tdata[1:0] == CMD_READ) begin
                  if (!ready_ff || req_row >= side_ff || req_col >= side_ff)
                     state_ff <= ST_RESP;
                  else if (req_tdata[1:0] == CMD_TRY) state_ff <= ST_TW_WAIT;
                  else state_ff <= ST_RD_WAIT;
               end else state_ff <= ST_RESP;
            end
            ST_INIT: begin
               if (row_ff[0] && col_ff[0] && init_val != LBL_SOLID)
                  next_lbl_ff <= next_lbl_ff + 1'b1;
               if (col_ff == side_ff - 1'b1) begin
                  col_ff <= '0;
                  if (row_ff == side_ff - 1'b1) begin
                     ready_ff <= 1'b1;
                     state_ff <= ST_RESP;
                  end else row_ff <= row_ff + 1'b1;
               end else col_ff <= col_ff + 1'b1;
            end
            ST_RD_WAIT: state_ff <= ST_RD_DONE;
            ST_RD_DONE: begin
               if (row_ff == side_ff - 2'd2 && col_ff == side_ff - 2'd2)
                  res_ff.cell_kind <= KIND_GOAL;
               else res_ff.cell_kind <= g_pos ? KIND_FLOOR : KIND_WALL;
               state_ff <= ST_RESP;
            end
            ST_TW_WAIT: state_ff <= ST_TW_CHECK;
            ST_TW_CHECK: begin
               wall_ff <= g_rdata;
               if (g_rdata == LBL_BRK_LR &&
                   col_ff >= 1 && col_ff + 1'b1 < side_ff) state_ff <= ST_TA_WAIT;
               else if (g_rdata == LBL_BRK_UD &&
                   row_ff >= 1 && row_ff + 1'b1 < side_ff) state_ff <= ST_TA_WAIT;
               else state_ff <= ST_RESP;
            end
            ST_TA_WAIT: state_ff <= ST_TA_GET;
            ST_TA_GET: begin first_ff <= g_rdata; state_ff <= ST_TB_WAIT; end
            ST_TB_WAIT: state_ff <= ST_TB_GET;
            ST_TB_GET: begin
               head_ff <= '0;
               tail_ff <= AddrWidth'(1);
               if (first_ff != g_rdata || rnd_ff < thresh_ff) begin
                  res_ff.opened <= 1'b1;
                  state_ff <= ST_FL_POP;
               end else state_ff <= ST_RESP;
            end
            ST_FL_POP: begin
               if (head_ff == tail_ff) state_ff <= ST_RESP;
               else begin
                  head_ff <= head_ff + 1'b1;
                  state_ff <= ST_FL_QWAIT;
               end
            end
            ST_FL_QWAIT: begin
               // The queue holds row and column side by side.
               qr_ff <= q_rdata[2*CoordWidth-1:CoordWidth];
               qc_ff <= q_rdata[CoordWidth-1:0];
               k_ff <= '0;
               state_ff <= ST_FL_NB;
            end
            ST_FL_NB: begin
               nb_addr_ff <= at(nb_r, nb_c);
               if (nb_ok) state_ff <= ST_FL_NWAIT;
               else if (k_ff == 2'd3) state_ff <= ST_FL_POP;
               else k_ff <= k_ff + 1'b1;
            end
            ST_FL_NWAIT: state_ff <= ST_FL_NCHK;
            ST_FL_NCHK: begin
               if (g_pos && g_rdata != first_ff) tail_ff <= tail_ff + 1'b1;
               if (k_ff == 2'd3) state_ff <= ST_FL_POP;
               else begin
                  k_ff <= k_ff + 1'b1;
                  state_ff <= ST_FL_NB;
               end
            end
            ST_RESP: if (!rsp_valid_ff || rsp_tready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'b0, rsp_data_ff.cell_kind, rsp_data_ff.opened};

`ifndef NO_ASSERTIONS
   a_goal_not_opened: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[2:1] != KIND_WALL))
      else $error("opened and cell kind both set");
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FL_NCHK |-> head_ff <= tail_ff)
      else $error("flood queue head passed tail");
   a_ready_after_init: assert property (@(posedge clock) disable iff (reset)
      $rose(ready_ff) |-> side_ff[0] && side_ff >= 5)
      else $error("side not odd or too small");
`endif
endmodule

// ----- bench/maze_cluster_merge_unit_test.sv -----
// Self-checking testbench for the maze cluster merge unit.
module maze_cluster_merge_unit_test;
   import mcm_pkg::*;

   localparam int Side = MaxSideDefault;
   localparam int Cells = Side * Side;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int HoldCycles = 400;

   class maze_board;
      int lbl[Cells];
      int fill_q[$];
      int side_len;
      bit built;
      int size_reg;
      int thresh_reg;
      result_type maze_expected[$];
      int mismatches;
      int checked;
      int walls_opened;

      function new();
         side_len = 0;
         built = 0;
         size_reg = 31;
         thresh_reg = 30;
         mismatches = 0;
         checked = 0;
         walls_opened = 0;
      endfunction

      function void set_reg(logic idx, logic [9:0] data);
         if (idx == CSR_GRID_SIZE) size_reg = data[5:0];
         else thresh_reg = data;
      endfunction

      function void build_grid();
         int n;
         int next_lbl;
         n = size_reg;
         next_lbl = 2;
         if (n < 5) n = 5;
         if (n > Side) n = Side;
         if (n % 2 == 0) n = n - 1;
         side_len = n;
         for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
               int v;
               v = 0;
               if (r >= 1 && r < n - 1 && c >= 1 && c < n - 1) begin
                  if (r % 2 == 1 && c % 2 == 1) begin
                     v = next_lbl;
                     next_lbl++;
                  end else if (r % 2 == 1) v = -1;
                  else if (c % 2 == 1) v = -2;
               end
               lbl[r * Side + c] = v;
            end
         built = 1;
      endfunction

      // Breadth-first relabel of the open region around the opened wall.
      function void relabel(int start, int target);
         int p;
         int nr;
         int nc;
         int q;
         lbl[start] = target;
         fill_q.delete();
         fill_q.push_back(start);
         while (fill_q.size() > 0) begin
            p = fill_q.pop_front();
            for (int k = 0; k < 4; k++) begin
               nr = p / Side + ((k == 1) ? -1 : (k == 3) ? 1 : 0);
               nc = p % Side + ((k == 0) ? 1 : (k == 2) ? -1 : 0);
               if (nr < 0 || nc < 0 || nr >= side_len || nc >= side_len) continue;
               q = nr * Side + nc;
               if (lbl[q] > 0 && lbl[q] != target) begin
                  lbl[q] = target;
                  fill_q.push_back(q);
               end
            end
         end
      endfunction

      function bit break_wall(int r, int c, int rnd);
         int w;
         int first;
         int second;
         if (!built || r >= side_len || c >= side_len) return 0;
         w = r * Side + c;
         if (lbl[w] == -1) begin
            if (c < 1 || c + 1 >= side_len) return 0;
            first = lbl[w + 1];
            second = lbl[w - 1];
         end else if (lbl[w] == -2) begin
            if (r < 1 || r + 1 >= side_len) return 0;
            first = lbl[w + Side];
            second = lbl[w - Side];
         end else return 0;
         if (first != second || rnd < thresh_reg) begin
            relabel(w, first);
            walls_opened++;
            return 1;
         end
         lbl[w] = 0;
         return 0;
      endfunction

      function void note_item(logic [23:0] item);
         result_type res;
         int r;
         int c;
         r = item[7:2];
         c = item[13:8];
         res = '0;
         case (item[1:0])
            CMD_INIT: build_grid();
            CMD_TRY: res.opened = break_wall(r, c, item[23:14]);
            CMD_READ: begin
               if (!built || r >= side_len || c >= side_len) res.cell_kind = KIND_WALL;
               else if (r == side_len - 2 && c == side_len - 2) res.cell_kind = KIND_GOAL;
               else if (lbl[r * Side + c] > 0) res.cell_kind = KIND_FLOOR;
               else res.cell_kind = KIND_WALL;
            end
            default: ;
         endcase
         maze_expected.push_back(res);
      endfunction

      function void check_result(logic [7:0] data);
         result_type exp_res;
         checked++;
         if (maze_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", data);
            return;
         end
         exp_res = maze_expected.pop_front();
         if (data[0] !== exp_res.opened || data[2:1] !== exp_res.cell_kind
             || data[7:3] !== 5'd0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected opened %0d kind %0d, got opened %b kind %b (%h)",
                        exp_res.opened, exp_res.cell_kind, data[0], data[2:1], data);
         end
      endfunction

      function int pending();
         return maze_expected.size();
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [7:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_index = 0;
   logic [9:0] csr_data = '0;

   maze_board board = new();
   bit calm = 0;
   bit hold_kick = 0;
   bit hold_seen = 0;
   int hold_left = 0;
   int items_sent = 0;
   int sizes_seen = 0;

   maze_cluster_merge_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Receiver: random stalls, plus a long hold-off whenever the main flow asks for one.
   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen = hold_kick;
         hold_left = HoldCycles;
      end
      if (reset) rsp_tready <= 0;
      else if (hold_left > 0) begin
         rsp_tready <= 0;
         hold_left = hold_left - 1;
      end else rsp_tready <= calm || ($urandom_range(0, 99) >= 25);
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);

   task automatic send_item(logic [1:0] cmd, int r, int c, int rnd);
      int gap;
      gap = (!calm && $urandom_range(0, 99) < 25) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {rnd[9:0], c[5:0], r[5:0], cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_item(req_tdata);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, int value);
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value[9:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_reg(idx, csr_data);
      csr_valid <= 0;
   endtask

   // A try on a random wall position that init marks as breakable.
   task automatic try_random_wall();
      int n;
      int r;
      int c;
      n = board.side_len;
      r = $urandom_range(1, n - 2);
      if (r % 2 == 1) c = 2 * $urandom_range(1, (n - 3) / 2);
      else c = 2 * $urandom_range(0, (n - 3) / 2) + 1;
      send_item(CMD_TRY, r, c, $urandom_range(0, 999));
   endtask

   task automatic run_phase(int count);
      int pick;
      sizes_seen++;
      send_item(CMD_INIT, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1023));
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) try_random_wall();
         else if (pick < 82)
            send_item(CMD_READ, $urandom_range(0, board.side_len - 1),
                      $urandom_range(0, board.side_len - 1), $urandom_range(0, 1023));
         else if (pick < 94)
            send_item(2'($urandom_range(1, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 1023));
         else if (pick < 97) send_item(CMD_INIT, 0, 0, 0);
         else send_item(CMD_UNKNOWN, $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 1023));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: before init, unknown command, grid extremes, and the wall cases.
      calm = 1;
      send_item(CMD_READ, 1, 1, 0);
      send_item(CMD_TRY, 1, 2, 0);
      send_item(CMD_UNKNOWN, 63, 63, 1023);
      send_item(CMD_INIT, 0, 0, 0);
      send_item(CMD_READ, 0, 0, 0);
      send_item(CMD_READ, 1, 1, 0);
      send_item(CMD_READ, 29, 29, 0);
      send_item(CMD_READ, 63, 63, 1023);
      send_item(CMD_READ, 31, 0, 0);
      send_item(CMD_READ, 1, 2, 0);
      send_item(CMD_TRY, 1, 1, 0);
      send_item(CMD_TRY, 0, 1, 0);
      send_item(CMD_TRY, 40, 2, 0);
      send_item(CMD_TRY, 1, 2, 999);
      send_item(CMD_TRY, 1, 2, 0);
      send_item(CMD_TRY, 2, 1, 1023);
      send_item(CMD_TRY, 2, 3, 999);
      send_item(CMD_TRY, 3, 2, 999);
      send_item(CMD_READ, 3, 2, 0);
      send_item(CMD_READ, 1, 2, 0);
      send_item(CMD_UNKNOWN, 0, 0, 0);
      calm = 0;

      run_phase(18);

      // Output backpressure: the receiver holds off while items keep coming.
      hold_kick = ~hold_kick;
      for (int i = 0; i < 6; i++) try_random_wall();
      drain();

      write_reg(CSR_GRID_SIZE, 5);
      write_reg(CSR_LOOP_THRESHOLD, 0);
      run_phase(18);
      write_reg(CSR_GRID_SIZE, 4);
      write_reg(CSR_LOOP_THRESHOLD, 1000);
      run_phase(14);
      write_reg(CSR_GRID_SIZE, 0);
      write_reg(CSR_LOOP_THRESHOLD, 1023);
      run_phase(12);
      write_reg(CSR_GRID_SIZE, 63);
      write_reg(CSR_LOOP_THRESHOLD, 30);
      run_phase(12);
      write_reg(CSR_GRID_SIZE, 62);
      write_reg(CSR_LOOP_THRESHOLD, 500);
      calm = 1;
      run_phase(16);
      calm = 0;
      write_reg(CSR_GRID_SIZE, 7 + 2 * $urandom_range(0, 8));
      write_reg(CSR_LOOP_THRESHOLD, $urandom_range(0, 1000));
      // The grid size is latched at init, so a new value alone must change nothing.
      write_reg(CSR_GRID_SIZE, 42);
      run_phase(0);
      write_reg(CSR_GRID_SIZE, 9);
      for (int i = 0; i < 10; i++) try_random_wall();
      run_phase(14);

      drain();
      repeat (50) @(posedge clock);
      $display("Sent %0d items over %0d grid setups; %0d results checked, %0d walls opened.",
               items_sent, sizes_seen, board.checked, board.walls_opened);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches, board.pending());
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #300_000_000;
      $display("timeout with %0d results outstanding", board.pending());
      $display("CHECK FAILED");
      $finish;
   end
endmodule
